@@ src/led_channel_store_serializer_top_defines.svh @@
// assertion macros shared by the led channel store serializer files
`ifndef LED_CHANNEL_STORE_SERIALIZER_TOP_DEFINES_SVH
`define LED_CHANNEL_STORE_SERIALIZER_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define LCSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define LCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/lcss_pkg.sv @@
// types, codes and constants of the led channel store serializer
package lcss_pkg;

  localparam int WORD_BITS = 12;
  localparam int TOP_BIT   = 11;

  localparam int CHANNELS_DEF   = 24;
  localparam int ROW_STRIDE_DEF = 16;
  localparam int ROW_TOP_DEF    = 16;

  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int GRID_X_W = 4;
  localparam int GRID_Y_W = 5;
  localparam int LEN_W    = 5;
  localparam int SHIFT_W  = 4;
  localparam int BIT_CNT_W = 4;

  localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OP_W-1:0] OP_POINT   = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd2;
  localparam logic [OP_W-1:0] OP_NORMAL  = 3'd3;
  localparam logic [OP_W-1:0] OP_ROTATED = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd5;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_BRIGHTNESS = 1'b0;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_NORMAL  = 3'b010,
    MODE_ROTATED = 3'b100
  } send_mode_e;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [POS_W-1:0]     position;
    logic [GRID_X_W-1:0]  grid_x;
    logic [GRID_Y_W-1:0]  grid_y;
    logic [WORD_BITS-1:0] value;
    logic [LEN_W-1:0]     frame_length;
  } in_item_t;

  typedef struct packed {
    logic bit_valid;
    logic data_bit;
    logic latch_level;
    logic blank_pulse;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic fill_en;
  } store_ctrl_t;

endpackage

@@ src/lcss_stream_if.sv @@
// valid/ready stream channel carrying one payload item per transfer
interface lcss_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/lcss_store.sv @@
// channel store memory with clearing and fill sweep
`include "led_channel_store_serializer_top_defines.svh"

module lcss_store #(
  parameter int CHANNELS = lcss_pkg::CHANNELS_DEF,
  parameter int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcss_pkg::store_ctrl_t         ctrl_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [AW-1:0]                 raddr_i,
  input  logic [lcss_pkg::WORD_BITS-1:0] wdata_i,
  output logic [lcss_pkg::WORD_BITS-1:0] rdata_o,
  output logic                          busy_o
);

  localparam logic [AW-1:0] LastAddr = AW'(CHANNELS - 1);

  logic [lcss_pkg::WORD_BITS-1:0] mem_q [CHANNELS];
  logic [lcss_pkg::WORD_BITS-1:0] rdata_q;

  logic                           sweep_active_q, sweep_active_d;
  logic [AW-1:0]                  sweep_addr_q, sweep_addr_d;
  logic [lcss_pkg::WORD_BITS-1:0] sweep_val_q, sweep_val_d;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [lcss_pkg::WORD_BITS-1:0] mem_wdata;

  // the sweep writes one entry a cycle, starting after reset with zero and on a fill with its value
  always_comb begin
    sweep_active_d = sweep_active_q;
    sweep_addr_d   = sweep_addr_q;
    sweep_val_d    = sweep_val_q;
    if (sweep_active_q) begin
      if (sweep_addr_q == LastAddr) begin
        sweep_active_d = 1'b0;
        sweep_addr_d   = '0;
      end else begin
        sweep_addr_d = sweep_addr_q + AW'(1);
      end
    end else if (ctrl_i.fill_en) begin
      sweep_active_d = 1'b1;
      sweep_addr_d   = '0;
      sweep_val_d    = wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_active_q <= 1'b1;
      sweep_addr_q   <= '0;
      sweep_val_q    <= '0;
    end else begin
      sweep_active_q <= sweep_active_d;
      sweep_addr_q   <= sweep_addr_d;
      sweep_val_q    <= sweep_val_d;
    end
  end

  assign mem_we    = sweep_active_q || ctrl_i.wr_en;
  assign mem_waddr = sweep_active_q ? sweep_addr_q : waddr_i;
  assign mem_wdata = sweep_active_q ? sweep_val_q : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = sweep_active_q;

  `LCSS_ASSERT_NOW(a_store_waddr_range, ctrl_i.wr_en, waddr_i <= LastAddr, "write address out of range")
  `LCSS_ASSERT_NOW(a_store_raddr_range, ctrl_i.rd_en, raddr_i <= LastAddr, "read address out of range")
  `LCSS_ASSERT_NOW(a_store_no_access_in_sweep, sweep_active_q, !ctrl_i.wr_en && !ctrl_i.rd_en && !ctrl_i.fill_en, "store access during sweep")

endmodule

@@ src/led_channel_store_serializer_top.sv @@
// Channel store and serial feeder for a daisy chain of 12-bit grayscale LED drivers. Items
// arrive on in_i and tick results leave on out_o; brightness_shift is selected by paddr[2] low.
// A tick that sends the first bit of a channel passes through the fetch state, because the level
// is read from the store memory through its registered read port. A fill of every channel sweeps
// the memory at one entry a cycle, and after reset the same sweep clears the store; no item is
// taken during a sweep, register writes are. An item is taken while a result waits in the output
// register only if that result leaves in the same cycle.
`include "led_channel_store_serializer_top_defines.svh"

module led_channel_store_serializer_top #(
  parameter int CHANNELS   = lcss_pkg::CHANNELS_DEF,
  parameter int ROW_STRIDE = lcss_pkg::ROW_STRIDE_DEF,
  parameter int ROW_TOP    = lcss_pkg::ROW_TOP_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lcss_stream_if.sink                     in_i,
  lcss_stream_if.source                   out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcss_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lcss_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lcss_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OffW  = $clog2(((2 ** lcss_pkg::GRID_X_W) - 1) * ROW_STRIDE + ROW_TOP + 1);
  localparam int RotW  = lcss_pkg::POS_W + 1;
  localparam int IdxA  = (OffW > RotW) ? OffW : RotW;
  localparam int IdxW  = (IdxA > $clog2(CHANNELS + 1)) ? IdxA : $clog2(CHANNELS + 1);
  localparam logic [AW-1:0] LastAddr = AW'(CHANNELS - 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_e;

  state_e                         st_q, st_d;
  lcss_pkg::send_mode_e           mode_q, mode_d;
  logic [lcss_pkg::LEN_W-1:0]     word_cnt_q, word_cnt_d;
  logic [lcss_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [lcss_pkg::WORD_BITS-1:0] shift_word_q, shift_word_d;
  logic [lcss_pkg::LEN_W-1:0]     frame_cnt_q, frame_cnt_d;
  logic [lcss_pkg::POS_W-1:0]     rot_start_q, rot_start_d;
  logic                           latch_q, latch_d;
  logic [lcss_pkg::SHIFT_W-1:0]   bright_q;

  logic                out_valid_q, out_valid_d;
  lcss_pkg::out_item_t out_data_q, out_data_d;

  lcss_pkg::in_item_t             item;
  logic                           in_fire;
  logic                           out_fire;
  logic                           store_busy;
  lcss_pkg::store_ctrl_t          store_ctrl;
  logic [AW-1:0]                  store_waddr;
  logic [AW-1:0]                  store_raddr;
  logic [lcss_pkg::WORD_BITS-1:0] store_rdata;
  logic [lcss_pkg::WORD_BITS-1:0] fetched;

  logic [IdxW-1:0] point_sum;
  logic [IdxW-1:0] point_off;
  logic            point_neg;
  logic [IdxW-1:0] rot_idx;
  logic            cfg_write;
  logic            cfg_index;

  function automatic logic [AW-1:0] clamp_idx(input logic [IdxW-1:0] idx);
    logic [AW-1:0] res;
    if (idx >= IdxW'(CHANNELS)) begin
      res = LastAddr;
    end else begin
      res = AW'(idx);
    end
    return res;
  endfunction

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= '0;
    end else if (cfg_write && (cfg_index == lcss_pkg::REG_BRIGHTNESS)) begin
      bright_q <= pwdata[lcss_pkg::SHIFT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_index == lcss_pkg::REG_BRIGHTNESS) begin
      prdata = lcss_pkg::APB_DATA_W'(bright_q);
    end
  end

  // handshakes
  assign item        = in_i.data;
  assign out_fire    = out_valid_q && out_o.ready;
  assign in_i.ready  = (st_q == ST_IDLE) && !store_busy && (!out_valid_q || out_o.ready);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // grid point offset x*stride + (top - y), negative means past the end
  assign point_sum = IdxW'(item.grid_x) * IdxW'(ROW_STRIDE) + IdxW'(ROW_TOP);
  assign point_neg = point_sum < IdxW'(item.grid_y);
  assign point_off = point_sum - IdxW'(item.grid_y);

  // rotated read index wraps once by the frame length
  always_comb begin
    rot_idx = IdxW'(word_cnt_q) + IdxW'(rot_start_q);
    if (rot_idx >= IdxW'(frame_cnt_q)) begin
      rot_idx = rot_idx - IdxW'(frame_cnt_q);
    end
  end

  always_comb begin
    if (mode_q == lcss_pkg::MODE_ROTATED) begin
      fetched = store_rdata;
    end else if (bright_q >= lcss_pkg::SHIFT_W'(lcss_pkg::WORD_BITS)) begin
      fetched = '0;
    end else begin
      fetched = store_rdata >> bright_q;
    end
  end

  always_comb begin
    st_d         = st_q;
    mode_d       = mode_q;
    word_cnt_d   = word_cnt_q;
    bit_cnt_d    = bit_cnt_q;
    shift_word_d = shift_word_q;
    frame_cnt_d  = frame_cnt_q;
    rot_start_d  = rot_start_q;
    latch_d      = latch_q;
    out_valid_d  = out_valid_q && !out_fire;
    out_data_d   = out_data_q;
    store_ctrl   = '0;
    store_waddr  = clamp_idx(IdxW'(item.position));
    store_raddr  = (mode_q == lcss_pkg::MODE_ROTATED) ? clamp_idx(rot_idx)
                                                      : clamp_idx(IdxW'(word_cnt_q));

    if (st_q == ST_FETCH) begin
      // first bit of a channel, level just read from the store
      st_d                   = ST_IDLE;
      shift_word_d           = fetched;
      bit_cnt_d              = lcss_pkg::BIT_CNT_W'(1);
      out_valid_d            = 1'b1;
      out_data_d             = '0;
      out_data_d.bit_valid   = 1'b1;
      out_data_d.data_bit    = fetched[lcss_pkg::TOP_BIT];
      out_data_d.latch_level = latch_q;
    end else if (in_fire) begin
      case (item.operation)
        lcss_pkg::OP_WRITE: begin
          store_ctrl.wr_en = 1'b1;
        end
        lcss_pkg::OP_POINT: begin
          store_ctrl.wr_en = 1'b1;
          store_waddr      = point_neg ? LastAddr : clamp_idx(point_off);
        end
        lcss_pkg::OP_FILL: begin
          store_ctrl.fill_en = 1'b1;
        end
        lcss_pkg::OP_NORMAL, lcss_pkg::OP_ROTATED: begin
          if (mode_q == lcss_pkg::MODE_IDLE) begin
            frame_cnt_d  = (32'(item.frame_length) > 32'(CHANNELS))
                           ? lcss_pkg::LEN_W'(CHANNELS) : item.frame_length;
            word_cnt_d   = '0;
            bit_cnt_d    = '0;
            shift_word_d = '0;
            if (item.operation == lcss_pkg::OP_NORMAL) begin
              mode_d = lcss_pkg::MODE_NORMAL;
            end else begin
              mode_d      = lcss_pkg::MODE_ROTATED;
              rot_start_d = item.position;
              latch_d     = 1'b0;
            end
          end
        end
        lcss_pkg::OP_TICK: begin
          out_data_d             = '0;
          out_data_d.latch_level = latch_q;
          if (mode_q == lcss_pkg::MODE_IDLE) begin
            out_valid_d = 1'b1;
          end else if (word_cnt_q < frame_cnt_q) begin
            if (bit_cnt_q == '0) begin
              store_ctrl.rd_en = 1'b1;
              st_d             = ST_FETCH;
            end else begin
              out_valid_d          = 1'b1;
              out_data_d.bit_valid = 1'b1;
              out_data_d.data_bit  =
                shift_word_q[lcss_pkg::BIT_CNT_W'(lcss_pkg::TOP_BIT) - bit_cnt_q];
              if (bit_cnt_q == lcss_pkg::BIT_CNT_W'(lcss_pkg::TOP_BIT)) begin
                bit_cnt_d  = '0;
                word_cnt_d = word_cnt_q + lcss_pkg::LEN_W'(1);
              end else begin
                bit_cnt_d = bit_cnt_q + lcss_pkg::BIT_CNT_W'(1);
              end
            end
          end else begin
            // closing step of the frame
            out_valid_d            = 1'b1;
            out_data_d.latch_level = 1'b1;
            out_data_d.frame_done  = 1'b1;
            out_data_d.blank_pulse = (mode_q == lcss_pkg::MODE_NORMAL);
            latch_d                = (mode_q != lcss_pkg::MODE_NORMAL);
            mode_d                 = lcss_pkg::MODE_IDLE;
            word_cnt_d             = '0;
            bit_cnt_d              = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      mode_q       <= lcss_pkg::MODE_IDLE;
      word_cnt_q   <= '0;
      bit_cnt_q    <= '0;
      shift_word_q <= '0;
      frame_cnt_q  <= '0;
      rot_start_q  <= '0;
      latch_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      mode_q       <= mode_d;
      word_cnt_q   <= word_cnt_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_word_q <= shift_word_d;
      frame_cnt_q  <= frame_cnt_d;
      rot_start_q  <= rot_start_d;
      latch_q      <= latch_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  lcss_store #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (store_ctrl),
    .waddr_i (store_waddr),
    .raddr_i (store_raddr),
    .wdata_i (item.value),
    .rdata_o (store_rdata),
    .busy_o  (store_busy)
  );

  `LCSS_ASSERT_NEXT(a_fetch_gives_result, st_q == ST_FETCH, out_valid_q && out_o.data.bit_valid, "fetch cycle produced no data bit")
  `LCSS_ASSERT_NOW(a_done_with_latch, out_valid_q && out_o.data.frame_done, out_o.data.latch_level && !out_o.data.bit_valid, "closing step without latch or with data")
  `LCSS_ASSERT_NOW(a_no_accept_in_sweep, store_busy, !in_i.ready, "item taken during store sweep")

endmodule

@@ tb/led_feed_checker.sv @@
// predicts the serial pin steps of the led channel store serializer and compares them
`timescale 1ns / 1ps

module led_feed_checker
  import lcss_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int ROW_STRIDE = ROW_STRIDE_DEF,
  parameter int ROW_TOP    = ROW_TOP_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  logic                  item_ready_i,
  input  in_item_t              item_i,
  input  logic                  step_valid_i,
  input  logic                  step_ready_i,
  input  out_item_t             step_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o,
  output logic                  frame_active_o,
  output int unsigned           steps_checked_o,
  output int unsigned           frames_closed_o
);

  localparam logic [APB_ADDR_W-1:0] BRIGHT_ADDR = {REG_BRIGHTNESS, 2'b00};

  logic [WORD_BITS-1:0] levels [CHANNELS];
  send_mode_e           mode;
  int                   word_cnt;
  int                   bit_cnt;
  logic [WORD_BITS-1:0] shifter;
  int                   frame_len;
  logic [POS_W-1:0]     rot_start;
  logic                 latch;
  logic [SHIFT_W-1:0]   shift_cfg;

  out_item_t   expected_steps [$];
  int unsigned mismatches;
  int unsigned steps_checked;
  int unsigned frames_closed;

  assign mismatches_o    = mismatches;
  assign pending_o       = expected_steps.size();
  assign frame_active_o  = (mode != MODE_IDLE);
  assign steps_checked_o = steps_checked;
  assign frames_closed_o = frames_closed;

  function automatic int clamp_channel(input int idx);
    return (idx >= CHANNELS) ? CHANNELS - 1 : idx;
  endfunction

  // level of the channel whose first bit goes out now
  function automatic logic [WORD_BITS-1:0] fetch_level();
    int j;
    if (mode == MODE_NORMAL) begin
      if (shift_cfg >= WORD_BITS) return '0;
      return levels[clamp_channel(word_cnt)] >> shift_cfg;
    end
    j = word_cnt + int'(rot_start);
    if (j >= frame_len) j -= frame_len;
    return levels[clamp_channel(j)];
  endfunction

  task automatic advance_feeder(input in_item_t it);
    int        off;
    out_item_t step;
    case (it.operation)
      OP_WRITE: levels[clamp_channel(int'(it.position))] = it.value;
      OP_POINT: begin
        off = int'(it.grid_x) * ROW_STRIDE + ROW_TOP - int'(it.grid_y);
        // above the top row the offset goes negative and lands on the last channel
        if (off < 0) off = CHANNELS;
        levels[clamp_channel(off)] = it.value;
      end
      OP_FILL: begin
        foreach (levels[i]) levels[i] = it.value;
      end
      OP_NORMAL, OP_ROTATED: begin
        if (mode == MODE_IDLE) begin
          frame_len = (int'(it.frame_length) > CHANNELS) ? CHANNELS : int'(it.frame_length);
          word_cnt  = 0;
          bit_cnt   = 0;
          shifter   = '0;
          if (it.operation == OP_NORMAL) begin
            mode = MODE_NORMAL;
          end else begin
            mode      = MODE_ROTATED;
            rot_start = it.position;
            latch     = 1'b0;
          end
        end
      end
      OP_TICK: begin
        step = '0;
        step.latch_level = latch;
        if (mode != MODE_IDLE) begin
          if (word_cnt < frame_len) begin
            if (bit_cnt == 0) shifter = fetch_level();
            step.bit_valid = 1'b1;
            step.data_bit  = shifter[TOP_BIT - bit_cnt];
            bit_cnt++;
            if (bit_cnt >= WORD_BITS) begin
              bit_cnt = 0;
              word_cnt++;
            end
          end else begin
            step.latch_level = 1'b1;
            step.frame_done  = 1'b1;
            if (mode == MODE_NORMAL) begin
              step.blank_pulse = 1'b1;
              latch = 1'b0;
            end else begin
              latch = 1'b1;
            end
            mode     = MODE_IDLE;
            word_cnt = 0;
            bit_cnt  = 0;
            frames_closed++;
          end
        end
        expected_steps.push_back(step);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %b got %b", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (levels[i]) levels[i] = '0;
      mode          = MODE_IDLE;
      word_cnt      = 0;
      bit_cnt       = 0;
      shifter       = '0;
      frame_len     = 0;
      rot_start     = '0;
      latch         = 1'b0;
      shift_cfg     = '0;
      mismatches    = 0;
      steps_checked = 0;
      frames_closed = 0;
      expected_steps.delete();
    end else begin
      // results leave before this edge's item can affect them
      if (step_valid_i && step_ready_i) begin
        if (expected_steps.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pin step, expected none got %b", $time, step_i);
        end else begin
          want = expected_steps.pop_front();
          check_field("bit_valid", want.bit_valid, step_i.bit_valid);
          check_field("data_bit", want.data_bit, step_i.data_bit);
          check_field("latch_level", want.latch_level, step_i.latch_level);
          check_field("blank_pulse", want.blank_pulse, step_i.blank_pulse);
          check_field("frame_done", want.frame_done, step_i.frame_done);
          steps_checked++;
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == BRIGHT_ADDR)
        shift_cfg = pwdata_i[SHIFT_W-1:0];
      if (item_valid_i && item_ready_i) advance_feeder(item_i);
    end
  end

endmodule

@@ tb/tb_led_channel_store_serializer_top.sv @@
// stimulus and verdict for the led channel store serializer, checked by led_feed_checker
`timescale 1ns / 1ps

module tb_led_channel_store_serializer_top;
  import lcss_pkg::*;

  localparam int CHANNELS   = CHANNELS_DEF;
  localparam int ROW_STRIDE = ROW_STRIDE_DEF;
  localparam int ROW_TOP    = ROW_TOP_DEF;
  localparam int PHASES     = 6;

  localparam logic [APB_ADDR_W-1:0] BRIGHT_ADDR = {REG_BRIGHTNESS, 2'b00};
  // codes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatches;
  int unsigned pending;
  logic        frame_active;
  int unsigned steps_checked;
  int unsigned frames_closed;
  int unsigned items_sent;
  int unsigned calm_left;

  lcss_stream_if #(.T(in_item_t))  in_ch ();
  lcss_stream_if #(.T(out_item_t)) out_ch ();

  led_channel_store_serializer_top #(
    .CHANNELS  (CHANNELS),
    .ROW_STRIDE(ROW_STRIDE),
    .ROW_TOP   (ROW_TOP)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  led_feed_checker #(
    .CHANNELS  (CHANNELS),
    .ROW_STRIDE(ROW_STRIDE),
    .ROW_TOP   (ROW_TOP)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (in_ch.valid),
    .item_ready_i   (in_ch.ready),
    .item_i         (in_ch.data),
    .step_valid_i   (out_ch.valid),
    .step_ready_i   (out_ch.ready),
    .step_i         (out_ch.data),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .frame_active_o (frame_active),
    .steps_checked_o(steps_checked),
    .frames_closed_o(frames_closed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_level();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return WORD_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic in_item_t rand_fields(input logic [OP_W-1:0] op);
    in_item_t it;
    it.operation    = op;
    it.position     = POS_W'($urandom_range(0, 63));
    it.grid_x       = GRID_X_W'($urandom_range(0, 15));
    it.grid_y       = ($urandom_range(0, 4) == 0) ? GRID_Y_W'($urandom_range(17, 31))
                                                   : GRID_Y_W'($urandom_range(0, 16));
    it.value        = rand_level();
    it.frame_length = LEN_W'($urandom_range(0, 31));
    return it;
  endfunction

  function automatic in_item_t store_item();
    int unsigned r;
    r = $urandom_range(0, 9);
    return rand_fields(r < 5 ? OP_WRITE : (r < 9 ? OP_POINT : OP_FILL));
  endfunction

  function automatic in_item_t item_of(input logic [OP_W-1:0] op, input int pos, input int gx,
                                       input int gy, input int val, input int len);
    in_item_t it;
    it.operation    = op;
    it.position     = POS_W'(pos);
    it.grid_x       = GRID_X_W'(gx);
    it.grid_y       = GRID_Y_W'(gy);
    it.value        = WORD_BITS'(val);
    it.frame_length = LEN_W'(len);
    return it;
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = idle_cycles();
      if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic write_brightness(input logic [SHIFT_W-1:0] shift);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BRIGHT_ADDR;
    pwdata  <= APB_DATA_W'(shift);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // frame item followed by its ticks, with store writes and stray frame items mixed in
  task automatic run_frame(input logic [OP_W-1:0] op, input int len);
    in_item_t    it;
    int          ticks;
    int unsigned r;
    it = rand_fields(op);
    it.frame_length = LEN_W'(len);
    send_item(it);
    ticks = ((len > CHANNELS) ? CHANNELS : len) * WORD_BITS + 1;
    if ($urandom_range(0, 9) == 0) ticks = $urandom_range(0, ticks);
    repeat (ticks) begin
      r = $urandom_range(0, 99);
      if (r < 6) send_item(store_item());
      else if (r < 8) send_item(rand_fields(r == 6 ? OP_NORMAL : OP_ROTATED));
      send_item(rand_fields(OP_TICK));
    end
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned start;
    int unsigned r;
    int          len;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item(rand_fields(OP_W'($urandom_range(0, 7))));
      end else if (r < 35) begin
        send_item(store_item());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(0, 2);
        else len = $urandom_range(3, 6);
        run_frame($urandom_range(0, 1) ? OP_NORMAL : OP_ROTATED, len);
      end
    end
  endtask

  // hold off until every step has arrived, closing any frame still open
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    while (frame_active) begin
      send_item(rand_fields(OP_TICK));
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
      while (pending != 0) @(negedge clk_i);
    end
    // a fill sweep may still be running after the last step
    repeat (CHANNELS + 8) @(negedge clk_i);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_cycles() > 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_cycles() + 1) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(40, 120) : $urandom_range(0, 5))
        @(negedge clk_i);
    end
  end

  initial begin
    logic [SHIFT_W-1:0] shift_plan [PHASES];
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rst_ni      = 1'b0;
    items_sent  = 0;
    calm_left   = 0;
    shift_plan  = '{4'd12, 4'd3, 4'd0, 4'd11, 4'd1, 4'd0};
    shift_plan[PHASES-1] = SHIFT_W'($urandom_range(0, 12));
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(item_of(OP_FILL, 0, 0, 0, 12'hfff, 0));
    send_item(item_of(OP_WRITE, 63, 0, 0, 12'h000, 0));
    send_item(item_of(OP_WRITE, 0, 15, 31, 12'ha5c, 31));
    send_item(item_of(OP_POINT, 0, 15, 0, 12'h7ff, 0));
    send_item(item_of(OP_POINT, 0, 0, 17, 12'h123, 0));
    send_item(item_of(OP_POINT, 0, 0, 15, 12'h001, 0));
    send_item(item_of(OP_SPARE_A, 63, 15, 31, 12'hfff, 31));
    send_item(item_of(OP_SPARE_B, 0, 0, 0, 12'h000, 0));
    send_item(item_of(OP_TICK, 0, 0, 0, 0, 0));
    // empty normal frame, and a rotated frame arriving while it is open
    send_item(item_of(OP_NORMAL, 0, 0, 0, 0, 0));
    send_item(item_of(OP_ROTATED, 5, 0, 0, 0, 3));
    send_item(item_of(OP_TICK, 0, 0, 0, 0, 0));
    send_item(item_of(OP_ROTATED, 63, 0, 0, 0, 0));
    send_item(item_of(OP_TICK, 0, 0, 0, 0, 0));
    send_item(item_of(OP_TICK, 0, 0, 0, 0, 0));
    send_item(item_of(OP_NORMAL, 0, 0, 0, 0, 1));
    repeat (WORD_BITS + 1) send_item(item_of(OP_TICK, 63, 15, 31, 12'hfff, 31));
    settle();

    foreach (shift_plan[p]) begin
      write_brightness(shift_plan[p]);
      // one full-length rotated frame with the length clamped
      if (p == 0) run_frame(OP_ROTATED, 31);
      random_items(8);
      settle();
    end

    $display("covered %0d items over %0d brightness settings: %0d pin steps checked, %0d frames",
             items_sent, PHASES, steps_checked, frames_closed);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ led_channel_store_serializer_top.f @@
+incdir+src
src/lcss_pkg.sv
src/lcss_stream_if.sv
src/lcss_store.sv
src/led_channel_store_serializer_top.sv
tb/led_feed_checker.sv
tb/tb_led_channel_store_serializer_top.sv
